@@ hdl/srr_pkg.sv @@
// Package for the sample report retransmit responder.
// Holds command codes, message characters, control types and the header table.
// No dependencies.
package srr_pkg;

    localparam int SAMPLE_FIELD_W  = 12;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIMEOUT_W       = 16;
    localparam int NUM_DIGITS      = 4;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int HEAD_LEN        = 5;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = 16'hFFFF;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_REQ  = 2'd1;
    localparam logic [1:0] MODE_ACK  = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEND
    } t_state;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_DIGIT,
        PH_CR,
        PH_LF
    } t_phase;

    // Result of one binary to decimal conversion
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] digits;
        logic [2:0]       num_digits;
    } t_conv_res;

    // Header "!ADC="
    function automatic logic [7:0] head_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h21;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h3D;
            default: b = 8'h21;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/srr_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on srr_pkg.
module srr_bcd #(
    parameter int VALUE_W = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_W-1:0]      i_value,
    output srr_pkg::t_conv_res      o_res
);

    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0]        r_bin;
    logic [srr_pkg::BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [srr_pkg::BCD_W-1:0] adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < srr_pkg::NUM_DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                        : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
            r_cnt <= CNT_W'(VALUE_W);
        end else if (r_busy) begin
            r_bcd <= {adj[srr_pkg::BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= r_bin << 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_res.done       = r_done;
    assign o_res.digits     = r_bcd;
    assign o_res.num_digits = (r_bcd[15:12] != 4'd0) ? 3'd4 :
                              (r_bcd[11:8]  != 4'd0) ? 3'd3 :
                              (r_bcd[7:4]   != 4'd0) ? 3'd2 : 3'd1;

endmodule

@@ hdl/srr_tx.sv @@
// Message serializer: streams "!ADC=<digits>\r\n" one byte per transaction.
// Shifts the decimal digits out one nibble at a time. Depends on srr_pkg.
module srr_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srr_pkg::t_conv_res i_conv,
    input  logic               i_resend,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte,
    output logic               o_is_resend
);

    logic                      r_busy;
    srr_pkg::t_phase           r_phase;
    logic [2:0]                r_head_idx;
    logic [2:0]                r_left;
    logic [srr_pkg::BCD_W-1:0] r_digits;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_last;
    logic                      r_resend;
    logic                      adv;
    logic [srr_pkg::BCD_W-1:0] aligned;

    // Move the leading significant digit to the top nibble
    always_comb begin
        case (i_conv.num_digits)
            3'd4:    aligned = i_conv.digits;
            3'd3:    aligned = {i_conv.digits[11:0], 4'd0};
            3'd2:    aligned = {i_conv.digits[7:0], 8'd0};
            default: aligned = {i_conv.digits[3:0], 12'd0};
        endcase
    end

    assign adv = r_busy && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_phase <= srr_pkg::PH_HEAD;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_conv.done) begin
                r_busy  <= 1'b1;
                r_phase <= srr_pkg::PH_HEAD;
            end else if (adv) begin
                case (r_phase)
                    srr_pkg::PH_HEAD: begin
                        if (r_head_idx == 3'(srr_pkg::HEAD_LEN - 1)) begin
                            r_phase <= srr_pkg::PH_DIGIT;
                        end
                    end
                    srr_pkg::PH_DIGIT: begin
                        if (r_left == 3'd1) begin
                            r_phase <= srr_pkg::PH_CR;
                        end
                    end
                    srr_pkg::PH_CR: r_phase <= srr_pkg::PH_LF;
                    default: begin
                        r_busy  <= 1'b0;
                        r_phase <= srr_pkg::PH_HEAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_conv.done) begin
            r_head_idx <= 3'd0;
            r_left     <= i_conv.num_digits;
            r_digits   <= aligned;
            r_resend   <= i_resend;
        end else if (adv) begin
            r_last <= 1'b0;
            case (r_phase)
                srr_pkg::PH_HEAD: begin
                    r_byte     <= srr_pkg::head_byte(r_head_idx);
                    r_head_idx <= r_head_idx + 3'd1;
                end
                srr_pkg::PH_DIGIT: begin
                    r_byte   <= srr_pkg::ASCII_ZERO | {4'd0, r_digits[15:12]};
                    r_digits <= r_digits << 4;
                    r_left   <= r_left - 3'd1;
                end
                srr_pkg::PH_CR: r_byte <= srr_pkg::ASCII_CR;
                default: begin
                    r_byte <= srr_pkg::ASCII_LF;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_tx_byte   = r_byte;
    assign o_last_byte = r_last;
    assign o_is_resend = r_resend;

endmodule

@@ hdl/sample_report_retransmit_responder.sv @@
// Top level of the sample report retransmit responder.
// Uses srr_pkg, srr_bcd and srr_tx.
//
// Stop-and-wait report responder. Each input transaction carries a mode
// (0 tick, 1 request, 2 acknowledge, 3 ignored) and the current converter
// sample. A request latches the sample, masked to SAMPLE_BITS, sends
// "!ADC=<decimal>\r\n" and starts waiting; an acknowledge ends the wait.
// While waiting, ticks are counted (saturating at 65535); once the count
// reaches the configured timeout the latched sample is sent again with
// is_resend set and the count restarts. A request while waiting restarts
// with the fresh sample. Timing: an item that sends nothing leaves the block
// idle, so such items can follow back to back. An item that sends a message
// occupies the block through accept, a converter start strobe, bit-serial
// decimal conversion of the latched sample bits (at most 12), a load of the
// serializer and the registering of the first byte, then 8 to 11 output
// transactions of one byte each, one per cycle while the sink is ready; the
// sink holding ready low stalls the output. The conversion loop takes one
// sample bit per cycle, and the output register is byte-wide. No new input
// transaction is taken until the last byte of a message has been accepted.
// The configuration channel is always ready; write the timeout only while
// the block is idle.
module sample_report_retransmit_responder #(
    parameter int SAMPLE_BITS = srr_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_adc_sample,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic        o_is_resend,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // Sample bits that survive the mask
    localparam int LATCH_W = (SAMPLE_BITS < srr_pkg::SAMPLE_FIELD_W) ?
                             SAMPLE_BITS : srr_pkg::SAMPLE_FIELD_W;

    srr_pkg::t_state              r_state, n_state;
    logic                         r_waiting, n_waiting;
    logic [srr_pkg::TIMEOUT_W-1:0] r_elapsed, n_elapsed;
    logic [srr_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [LATCH_W-1:0]           r_latched, n_latched;
    logic                         r_resend, n_resend;
    logic                         r_conv_start, n_conv_start;

    logic                         accept;
    logic                         last_out;
    logic [srr_pkg::TIMEOUT_W-1:0] tick_count;
    srr_pkg::t_conv_res           conv_res;

    assign o_in_ready  = (r_state == srr_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign last_out    = o_out_valid && i_out_ready && o_last_byte;

    // Saturating tick count
    assign tick_count = (r_elapsed != srr_pkg::TICKS_MAX) ?
                        r_elapsed + srr_pkg::TIMEOUT_W'(1) : r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srr_pkg::ST_IDLE;
            r_waiting    <= 1'b0;
            r_elapsed    <= '0;
            r_latched    <= '0;
            r_timeout    <= srr_pkg::TIMEOUT_RESET;
            r_resend     <= 1'b0;
            r_conv_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_waiting    <= n_waiting;
            r_elapsed    <= n_elapsed;
            r_latched    <= n_latched;
            r_resend     <= n_resend;
            r_conv_start <= n_conv_start;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_waiting    = r_waiting;
        n_elapsed    = r_elapsed;
        n_latched    = r_latched;
        n_resend     = r_resend;
        n_conv_start = 1'b0;
        case (r_state)
            srr_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        srr_pkg::MODE_REQ: begin
                            // latch fresh sample, restart the wait
                            n_latched    = i_adc_sample[LATCH_W-1:0];
                            n_waiting    = 1'b1;
                            n_elapsed    = '0;
                            n_resend     = 1'b0;
                            n_conv_start = 1'b1;
                            n_state      = srr_pkg::ST_CONV;
                        end
                        srr_pkg::MODE_ACK: begin
                            n_waiting = 1'b0;
                        end
                        srr_pkg::MODE_TICK: begin
                            if (r_waiting) begin
                                if (tick_count >= r_timeout) begin
                                    // timeout: resend latched sample
                                    n_elapsed    = '0;
                                    n_resend     = 1'b1;
                                    n_conv_start = 1'b1;
                                    n_state      = srr_pkg::ST_CONV;
                                end else begin
                                    n_elapsed = tick_count;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            srr_pkg::ST_CONV: begin
                // hold until the digits are handed to the serializer
                if (conv_res.done) begin
                    n_state = srr_pkg::ST_SEND;
                end
            end
            srr_pkg::ST_SEND: begin
                if (last_out) begin
                    n_state = srr_pkg::ST_IDLE;
                end
            end
            default: n_state = srr_pkg::ST_IDLE;
        endcase
    end

    srr_bcd #(
        .VALUE_W (LATCH_W)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_conv_start),
        .i_value (r_latched),
        .o_res   (conv_res)
    );

    srr_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_conv      (conv_res),
        .i_resend    (r_resend),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte),
        .o_is_resend (o_is_resend)
    );

endmodule
